/* src/imhq_pkg.sv */
// Package for the indexed max-heap threshold queue.
// Types, constants and opcodes shared by all modules; no dependencies.
`default_nettype none
package imhq_pkg;
  localparam int ELEMENTS = 256;
  localparam int QUEUES = 2;
  localparam int EW = $clog2(ELEMENTS);
  localparam int QW = $clog2(QUEUES);
  localparam int AW = QW + EW;
  localparam int DEPTH = QUEUES * ELEMENTS;
  localparam int PW = EW + 1;
  localparam int CW = EW + 1;
  localparam logic [31:0] KEY_MAX = 32'hFFFF_FFFF;

  typedef enum logic {OP_INCREASE = 1'b0, OP_REMOVE = 1'b1} opcode_t;
  typedef enum logic {ST_OK = 1'b0, ST_NOT_QUEUED = 1'b1} status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_ELEM, S_INC, S_REM, S_RM_ID, S_RM_KEY,
    S_UP_RD, S_UP_ID, S_UP_KEY, S_UP_END,
    S_DN_RD, S_DN_ID, S_DN_KEY, S_DN_ID2, S_DN_KEY2, S_DN_CMP, S_DN_END,
    S_TOP_RD, S_TOP_ID, S_TOP_KEY, S_DONE
  } state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? KEY_MAX : s[31:0];
  endfunction
endpackage
`default_nettype wire

/* src/indexed_max_heap_threshold_queue.sv */
// Indexed max-heap threshold queue: sequencer around key, position and slot RAMs
// (imhq_ram), types and sizes from imhq_pkg.
// Accept to done: an increase above epsilon lets the key climb the heap; a remove of a
// non-last entry moves the last key into its slot, which climbs and then sinks level by level.
// One word at a time: next start is taken the cycle after done; receiver cannot stall.
// Reset: rst starts a clear of all 512 key and position words, busy high meanwhile.
`default_nettype none
module indexed_max_heap_threshold_queue
  import imhq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        opcode,
  input  wire logic        queue_sel,
  input  wire logic [7:0]  element_id,
  input  wire logic [31:0] amount,
  output logic             done,
  output logic             status,
  output logic [8:0]       heap_count,
  output logic             top_valid,
  output logic [7:0]       top_id,
  output logic [31:0]      top_key
);
  state_t state, state_next;
  logic [31:0] epsilon;
  logic [CW-1:0] sizes [QUEUES];
  logic [AW-1:0] clr;
  opcode_t op;
  logic [QW-1:0] q;
  logic [EW-1:0] elem, moved, pos, cid, oid, top_id_r;
  logic [31:0] amt, k, ckey, top_key_r;
  logic [CW-1:0] child;
  status_t st;

  logic k_we, p_we, h_we;
  logic [AW-1:0] k_a, p_a, h_a;
  logic [31:0] k_wd, k_rd;
  logic [PW-1:0] p_wd, p_rd;
  logic [EW-1:0] h_wd, h_rd;

  logic queued;
  logic [EW-1:0] ppos, par, last;
  logic [CW-1:0] size_q, lchild;
  logic [CW:0] rchild;
  logic [31:0] sum;

  imhq_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_key (
    .clk(clk), .we(k_we), .addr(k_a), .wdata(k_wd), .rdata(k_rd));
  imhq_ram #(.DEPTH(DEPTH), .WIDTH(PW)) u_pos (
    .clk(clk), .we(p_we), .addr(p_a), .wdata(p_wd), .rdata(p_rd));
  imhq_ram #(.DEPTH(DEPTH), .WIDTH(EW)) u_slot (
    .clk(clk), .we(h_we), .addr(h_a), .wdata(h_wd), .rdata(h_rd));

  // position word: MSB = queued, low bits = slot
  assign queued = p_rd[PW-1];
  assign ppos = p_rd[EW-1:0];
  assign size_q = sizes[q];
  assign last = size_q[EW-1:0] - EW'(1);
  assign par = (pos - EW'(1)) >> 1;
  assign lchild = {pos, 1'b1};
  assign rchild = {1'b0, child} + (CW+1)'(1);
  assign sum = sat_add(k_rd, amt);

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:    if (start) state_next = S_RD_ELEM;
      S_RD_ELEM: state_next = (op == OP_REMOVE) ? S_REM : S_INC;
      S_INC:     state_next = (sum > epsilon) ? S_UP_RD : S_TOP_RD;
      S_REM:     state_next = (queued && ppos != last) ? S_RM_ID : S_TOP_RD;
      S_RM_ID:   state_next = S_RM_KEY;
      S_RM_KEY:  state_next = S_UP_RD;
      S_UP_RD:   state_next = (pos == '0) ? S_UP_END : S_UP_ID;
      S_UP_ID:   state_next = S_UP_KEY;
      S_UP_KEY:  state_next = (k > k_rd) ? S_UP_RD : S_UP_END;
      S_UP_END:  state_next = (op == OP_REMOVE) ? S_DN_RD : S_TOP_RD;
      S_DN_RD:   state_next = (lchild < size_q) ? S_DN_ID : S_DN_END;
      S_DN_ID:   state_next = S_DN_KEY;
      S_DN_KEY:  state_next = (rchild < {1'b0, size_q}) ? S_DN_ID2 : S_DN_CMP;
      S_DN_ID2:  state_next = S_DN_KEY2;
      S_DN_KEY2: state_next = S_DN_CMP;
      S_DN_CMP:  state_next = (k < ckey) ? S_DN_RD : S_DN_END;
      S_DN_END:  state_next = S_TOP_RD;
      S_TOP_RD:  state_next = (size_q == '0) ? S_DONE : S_TOP_ID;
      S_TOP_ID:  state_next = S_TOP_KEY;
      S_TOP_KEY: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    k_we = 1'b0; p_we = 1'b0; h_we = 1'b0;
    k_a = {q, elem}; p_a = {q, elem}; h_a = {q, elem};
    k_wd = sum; p_wd = {1'b1, pos}; h_wd = moved;
    unique case (state)
      S_CLEAR: begin
        k_we = 1'b1; p_we = 1'b1; k_a = clr; p_a = clr; k_wd = '0; p_wd = '0;
      end
      S_INC: k_we = 1'b1;
      S_REM: begin
        p_we = queued; p_wd = '0;
        h_a = {q, last};
      end
      S_RM_ID, S_UP_ID, S_DN_ID, S_DN_ID2, S_TOP_ID: k_a = {q, h_rd};
      S_UP_RD: h_a = {q, par};
      S_UP_KEY: if (k > k_rd) begin
        h_we = 1'b1; h_a = {q, pos}; h_wd = cid;
        p_we = 1'b1; p_a = {q, cid};
      end
      S_UP_END, S_DN_END: begin
        h_we = 1'b1; h_a = {q, pos};
        p_we = 1'b1; p_a = {q, moved};
      end
      S_DN_RD:  h_a = {q, lchild[EW-1:0]};
      S_DN_KEY: h_a = {q, rchild[EW-1:0]};
      S_DN_CMP: if (k < ckey) begin
        h_we = 1'b1; h_a = {q, pos}; h_wd = cid;
        p_we = 1'b1; p_a = {q, cid};
      end
      S_TOP_RD: h_a = {q, {EW{1'b0}}};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      epsilon <= '0;
      st <= ST_OK;
      for (int i = 0; i < QUEUES; i++) sizes[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) epsilon <= cfg_data;
      unique case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: if (start) begin
          op <= opcode_t'(opcode); q <= queue_sel; elem <= element_id;
          amt <= amount; st <= ST_OK;
        end
        S_INC: begin
          k <= sum; moved <= elem;
          if (sum > epsilon) begin
            if (!queued) begin
              pos <= size_q[EW-1:0];
              sizes[q] <= size_q + CW'(1);
            end else pos <= ppos;
          end
        end
        S_REM: begin
          if (!queued) st <= ST_NOT_QUEUED;
          else begin
            sizes[q] <= size_q - CW'(1);
            pos <= ppos;
          end
        end
        S_RM_ID: moved <= h_rd;
        S_RM_KEY: k <= k_rd;
        S_UP_ID, S_DN_ID: cid <= h_rd;
        S_UP_KEY: if (k > k_rd) pos <= par;
        S_DN_RD: child <= lchild;
        S_DN_KEY: ckey <= k_rd;
        S_DN_ID2: oid <= h_rd;
        S_DN_KEY2: if (ckey < k_rd) begin
          ckey <= k_rd; cid <= oid; child <= rchild[CW-1:0];
        end
        S_DN_CMP: if (k < ckey) pos <= child[EW-1:0];
        S_TOP_ID: top_id_r <= h_rd;
        S_TOP_KEY: top_key_r <= k_rd;
        default: ;
      endcase
    end
  end

  assign status = st;
  assign heap_count = size_q;
  assign top_valid = (size_q != '0);
  assign top_id = top_valid ? top_id_r : '0;
  assign top_key = top_valid ? top_key_r : '0;

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("strobe longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("ready during result");
  a_count: assert property (@(posedge clk) disable iff (rst) heap_count <= CW'(ELEMENTS))
    else $error("heap overflow");
endmodule
`default_nettype wire

/* src/imhq_ram.sv */
// Single-port synchronous RAM with registered read.
// Used for keys, positions and heap slots; DEPTH default from imhq_pkg.
`default_nettype none
module imhq_ram
  import imhq_pkg::*;
#(
  parameter int DEPTH = imhq_pkg::DEPTH,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
